### rtl/tmh_pkg.sv
// Shared constants and controller/datapath interface types for the ternary max-heap.
package tmh_pkg;

   // Payload widths
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   // Default heap depth
   localparam int DEF_CAPACITY = 1024;

   // Operation codes
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_req;    // capture request value, clear result fields
      logic push_start;  // hole at end of heap, bump count
      logic push_fail;   // flag push on full heap
      logic pop_fail;    // flag pop on empty heap
      logic rd_root;     // read slot 0
      logic rd_parent;   // read parent of hole, latch parent index
      logic up_move;     // write parent value into hole, hole moves up
      logic wr_cur;      // write moving value into hole
      logic pop_take;    // latch root, drop count, read last slot
      logic load_last;   // moving value is old last element, hole at root
      logic rd_first;    // read first child of hole
      logic rd_next;     // read next child of hole
      logic take_child;  // fold returned child into best candidate
      logic dn_move;     // write best child into hole, hole moves down
      logic load_rsp;    // load result register
   } tmh_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic full;         // count at capacity
      logic empty;        // count is zero
      logic last_one;     // count is one
      logic pos_zero;     // hole at root
      logic parent_less;  // parent value below moving value
      logic no_child;     // hole has no child in range
      logic next_ok;      // another child of this hole is in range
      logic cur_less;     // moving value below best child
      logic rsp_free;     // result register can take a new transaction
   } tmh_stat_type;

endpackage

### rtl/tmh_ctrl.sv
// Sequencing state machine for push sift-up and pop sift-down.
module tmh_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_mode,
   output logic                  req_ready,
   input  tmh_pkg::tmh_stat_type stat,
   output tmh_pkg::tmh_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_UP_CHK   = 4'd1;
   localparam logic [3:0] S_UP_CMP   = 4'd2;
   localparam logic [3:0] S_POP_ROOT = 4'd3;
   localparam logic [3:0] S_POP_LAST = 4'd4;
   localparam logic [3:0] S_DN_CHK   = 4'd5;
   localparam logic [3:0] S_DN_RD    = 4'd6;
   localparam logic [3:0] S_DN_CMP   = 4'd7;
   localparam logic [3:0] S_FIN      = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Decode state and status into datapath commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (req_mode == tmh_pkg::MODE_PUSH) begin
                  if (stat.full) begin
                     cmd.push_fail = 1'b1;
                     state_in      = S_FIN;
                  end else begin
                     cmd.push_start = 1'b1;
                     state_in       = S_UP_CHK;
                  end
               end else begin
                  if (stat.empty) begin
                     cmd.pop_fail = 1'b1;
                     state_in     = S_FIN;
                  end else begin
                     cmd.rd_root = 1'b1;
                     state_in    = S_POP_ROOT;
                  end
               end
            end
         end
         S_UP_CHK: begin
            if (stat.pos_zero) begin
               cmd.wr_cur = 1'b1;
               state_in   = S_FIN;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in      = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.parent_less) begin
               cmd.up_move = 1'b1;
               state_in    = S_UP_CHK;
            end else begin
               cmd.wr_cur = 1'b1;
               state_in   = S_FIN;
            end
         end
         S_POP_ROOT: begin
            cmd.pop_take = 1'b1;
            state_in     = stat.last_one ? S_FIN : S_POP_LAST;
         end
         S_POP_LAST: begin
            cmd.load_last = 1'b1;
            state_in      = S_DN_CHK;
         end
         S_DN_CHK: begin
            if (stat.no_child) begin
               cmd.wr_cur = 1'b1;
               state_in   = S_FIN;
            end else begin
               cmd.rd_first = 1'b1;
               state_in     = S_DN_RD;
            end
         end
         S_DN_RD: begin
            cmd.take_child = 1'b1;
            if (stat.next_ok) begin
               cmd.rd_next = 1'b1;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (stat.cur_less) begin
               cmd.dn_move = 1'b1;
               state_in    = S_DN_CHK;
            end else begin
               cmd.wr_cur = 1'b1;
               state_in   = S_FIN;
            end
         end
         S_FIN: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/tmh_dp.sv
// Heap memory, hole pointer, count, child compare and result register.
module tmh_dp #(
   parameter int CAPACITY = tmh_pkg::DEF_CAPACITY
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [tmh_pkg::VALUE_W-1:0]    req_value,
   input  tmh_pkg::tmh_cmd_type                  cmd,
   output tmh_pkg::tmh_stat_type                 stat,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [tmh_pkg::VALUE_W-1:0]    rsp_popped_value,
   output logic        [tmh_pkg::STATUS_W-1:0]   rsp_status,
   output logic        [tmh_pkg::COUNT_W-1:0]    rsp_count,
   output logic                                  rsp_is_empty
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int XW    = IDX_W + 2;
   // Reciprocal of three, exact for every index below 2**IDX_W
   localparam int RK    = IDX_W + 2;
   localparam logic [RK-1:0] RECIP = RK'(((1 << RK) + 2) / 3);
   localparam int PW    = IDX_W + RK;

   localparam int VW = tmh_pkg::VALUE_W;

   // Heap storage
   logic signed [VW-1:0] mem [CAPACITY];
   logic signed [VW-1:0] rd_data_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 rd_en;
   logic [IDX_W-1:0]     wr_addr;
   logic signed [VW-1:0] wr_data;
   logic                 wr_en;

   // Working registers
   logic signed [VW-1:0] cur_ff;
   logic [IDX_W-1:0]     pos_ff;
   logic [IDX_W-1:0]     par_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [XW-1:0]        child_ff;
   logic [1:0]           kid_ff;
   logic signed [VW-1:0] best_val_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic signed [VW-1:0] popped_ff;
   logic [tmh_pkg::STATUS_W-1:0] status_ff;

   // Result register
   logic                         rsp_valid_ff;
   logic signed [VW-1:0]         rsp_popped_ff;
   logic [tmh_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [tmh_pkg::COUNT_W-1:0]  rsp_count_ff;
   logic                         rsp_empty_ff;

   // Index arithmetic
   logic [IDX_W-1:0] pos_m1;
   logic [PW-1:0]    par_prod;
   logic [IDX_W-1:0] par_idx;
   logic [XW-1:0]    first_idx;
   logic [XW-1:0]    next_idx;
   logic [XW-1:0]    cnt_x;
   logic [CNT_W-1:0] cnt_m1;

   assign pos_m1    = pos_ff - IDX_W'(1);
   assign par_prod  = PW'(pos_m1) * PW'(RECIP);
   assign par_idx   = par_prod[RK +: IDX_W];
   assign first_idx = XW'(XW'(pos_ff) * XW'(3) + XW'(1));
   assign next_idx  = child_ff + XW'(1);
   assign cnt_x     = XW'(cnt_ff);
   assign cnt_m1    = cnt_ff - CNT_W'(1);

   // Status to controller
   always_comb begin
      stat.full        = (cnt_ff == CNT_W'(CAPACITY));
      stat.empty       = (cnt_ff == '0);
      stat.last_one    = (cnt_ff == CNT_W'(1));
      stat.pos_zero    = (pos_ff == '0);
      stat.parent_less = (rd_data_ff < cur_ff);
      stat.no_child    = (first_idx >= cnt_x);
      stat.next_ok     = (kid_ff != 2'd2) && (next_idx < cnt_x);
      stat.cur_less    = (cur_ff < best_val_ff);
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // Select memory read address
   always_comb begin
      rd_en   = 1'b1;
      rd_addr = '0;
      if (cmd.rd_parent) begin
         rd_addr = par_idx;
      end else if (cmd.pop_take) begin
         rd_addr = cnt_m1[IDX_W-1:0];
      end else if (cmd.rd_first) begin
         rd_addr = first_idx[IDX_W-1:0];
      end else if (cmd.rd_next) begin
         rd_addr = next_idx[IDX_W-1:0];
      end else if (!cmd.rd_root) begin
         rd_en = 1'b0;
      end
   end

   // Select memory write
   always_comb begin
      wr_en   = cmd.wr_cur || cmd.up_move || cmd.dn_move;
      wr_addr = pos_ff;
      if (cmd.up_move) begin
         wr_data = rd_data_ff;
      end else if (cmd.dn_move) begin
         wr_data = best_val_ff;
      end else begin
         wr_data = cur_ff;
      end
   end

   // Memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Working payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cur_ff    <= req_value;
         popped_ff <= '0;
         // Flag a failed operation as the request is taken
         if (cmd.push_fail) begin
            status_ff <= tmh_pkg::ST_FULL;
         end else if (cmd.pop_fail) begin
            status_ff <= tmh_pkg::ST_EMPTY;
         end else begin
            status_ff <= tmh_pkg::ST_OK;
         end
      end
      if (cmd.push_start) begin
         pos_ff <= cnt_ff[IDX_W-1:0];
      end
      if (cmd.rd_parent) begin
         par_ff <= par_idx;
      end
      if (cmd.up_move) begin
         pos_ff <= par_ff;
      end
      if (cmd.pop_take) begin
         popped_ff <= rd_data_ff;
      end
      if (cmd.load_last) begin
         cur_ff <= rd_data_ff;
         pos_ff <= '0;
      end
      if (cmd.rd_first) begin
         child_ff <= first_idx;
         kid_ff   <= '0;
      end
      // Keep lowest-index child among the largest
      if (cmd.take_child) begin
         if (kid_ff == '0 || rd_data_ff > best_val_ff) begin
            best_val_ff <= rd_data_ff;
            best_idx_ff <= child_ff[IDX_W-1:0];
         end
      end
      if (cmd.rd_next) begin
         child_ff <= next_idx;
         kid_ff   <= kid_ff + 2'd1;
      end
      if (cmd.dn_move) begin
         pos_ff <= best_idx_ff;
      end
   end

   // Element count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.push_start) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end else if (cmd.pop_take) begin
         cnt_ff <= cnt_m1;
      end
   end

   // Result transaction register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_popped_ff <= popped_ff;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= tmh_pkg::COUNT_W'(cnt_ff);
         rsp_empty_ff  <= (cnt_ff == '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_count        = rsp_count_ff;
   assign rsp_is_empty     = rsp_empty_ff;

endmodule

### rtl/ternary_max_heap_core.sv
// Ternary max-heap priority queue: top level joining controller and datapath.
//
// Usage: a request transaction on req_* carries req_mode (0 push, 1 pop) and
// req_value. Every request yields exactly one response transaction on rsp_*
// with the popped maximum (zero unless a pop succeeded), a status code
// (0 ok, 1 pop on empty, 2 push on full), the element count after the
// operation and an empty flag. One request is in work at a time; req_ready
// is high only while the engine is idle.
// A push reads the parent and moves the hole up once for each level climbed;
// a pop reads the root, then the last element, and for each level descended
// reads up to three children through the single memory read port before it
// moves the hole down. Popping the only element and a failed operation skip
// the sift entirely. The engine is idle again, and can accept the next
// request, in the same cycle that the response becomes valid.
// Reset clears the element count and the response valid flag; the heap memory
// needs no clearing, as only slots below the count are ever read.
// A stalled receiver holds the response in its output register; the engine takes
// the next request, then waits with that result and takes no further one until it drains.
module ternary_max_heap_core #(
   parameter int CAPACITY = tmh_pkg::DEF_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic signed [tmh_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tmh_pkg::VALUE_W-1:0]  rsp_popped_value,
   output logic        [tmh_pkg::STATUS_W-1:0] rsp_status,
   output logic        [tmh_pkg::COUNT_W-1:0]  rsp_count,
   output logic                                rsp_is_empty
);

   tmh_pkg::tmh_cmd_type  cmd;
   tmh_pkg::tmh_stat_type stat;

   // Sequencer
   tmh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage and compare datapath
   tmh_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_value        (req_value),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_count        (rsp_count),
      .rsp_is_empty     (rsp_is_empty)
   );

endmodule
